/* sv/stunmap_pkg.sv */
// ----------------------------------------------------------------------------
// STUN mapped-address parser package
// Shared types and constants for the datagram attribute walker.
// ----------------------------------------------------------------------------
package stunmap_pkg;

  localparam logic [31:0] MAGIC_COOKIE    = 32'h2112_A442;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
  localparam logic [7:0]  HEADER_BYTE     = 8'h01;
  localparam logic [15:0] HEADER_LEN      = 16'd20;
  localparam logic [15:0] MIN_ATTR_LEN    = 16'd8;
  localparam logic [15:0] POS_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_VALUE = 2'd1,
    PH_PAD   = 2'd2
  } walk_phase_t;

  typedef struct packed {
    logic        found;
    logic [31:0] ext_addr;
    logic [15:0] ext_port;
  } result_t;

endpackage

/* sv/stunmap_in_if.sv */
// ----------------------------------------------------------------------------
// STUN parser input channel
// One datagram byte per beat, with a last-byte marker.
// ----------------------------------------------------------------------------
interface stunmap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_datagram;

  modport source (output valid, output data_byte, output end_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

/* sv/stunmap_out_if.sv */
// ----------------------------------------------------------------------------
// STUN parser result channel
// One result beat per datagram: found flag, address and port.
// ----------------------------------------------------------------------------
interface stunmap_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] ext_addr;
  logic [15:0] ext_port;

  modport source (output valid, output found, output ext_addr, output ext_port, input ready);
  modport sink   (input valid, input found, input ext_addr, input ext_port, output ready);
endinterface

/* sv/stunmap_walk.sv */
// ----------------------------------------------------------------------------
// STUN attribute walker
// Tracks header check and attribute walk one byte per beat and decodes the
// first IPv4 XOR mapped address attribute.
// ----------------------------------------------------------------------------
module stunmap_walk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 beat_en,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output stunmap_pkg::result_t result
);

  logic [15:0]              pos_r, pos_nxt;
  logic                     hg_r, hg_nxt;
  stunmap_pkg::walk_phase_t phase_r, phase_nxt;
  logic                     stop_r, stop_nxt;
  logic [1:0]               hcnt_r, hcnt_nxt;
  logic [15:0]              kind_r, kind_nxt;
  logic [15:0]              len_r, len_nxt;
  logic [15:0]              left_r, left_nxt;
  logic [7:0]               fam_r, fam_nxt;
  logic [15:0]              cport_r, cport_nxt;
  logic [31:0]              caddr_r, caddr_nxt;
  logic                     hit_r, hit_nxt;
  logic [15:0]              hport_r, hport_nxt;
  logic [31:0]              haddr_r, haddr_nxt;
  logic [15:0]              vidx;
  logic [1:0]               pad;

  always_comb begin
    pos_nxt   = (pos_r == stunmap_pkg::POS_MAX) ? pos_r : pos_r + 16'd1;
    hg_nxt    = hg_r;
    phase_nxt = phase_r;
    stop_nxt  = stop_r;
    hcnt_nxt  = hcnt_r;
    kind_nxt  = kind_r;
    len_nxt   = len_r;
    left_nxt  = left_r;
    fam_nxt   = fam_r;
    cport_nxt = cport_r;
    caddr_nxt = caddr_r;
    hit_nxt   = hit_r;
    hport_nxt = hport_r;
    haddr_nxt = haddr_r;
    vidx      = len_r - left_r;
    pad       = 2'd0;
    if (pos_r == 16'd0) begin
      hg_nxt = (data_byte == stunmap_pkg::HEADER_BYTE);
    end else if (pos_r == 16'd1) begin
      hg_nxt = hg_r && (data_byte == stunmap_pkg::HEADER_BYTE);
    end else if (pos_r >= stunmap_pkg::HEADER_LEN && !stop_r) begin
      case (phase_r)
        stunmap_pkg::PH_VALUE: begin
          if (vidx == 16'd1) begin
            fam_nxt = data_byte;
          end else if (vidx == 16'd2) begin
            cport_nxt = {data_byte, 8'h00};
          end else if (vidx == 16'd3) begin
            cport_nxt = cport_r | {8'h00, data_byte};
          end else if (vidx >= 16'd4 && vidx <= 16'd7) begin
            caddr_nxt = {caddr_r[23:0], data_byte};
          end
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            if (hg_r && kind_r == stunmap_pkg::ATTR_XOR_MAPPED &&
                len_r >= stunmap_pkg::MIN_ATTR_LEN &&
                fam_nxt == stunmap_pkg::FAMILY_IPV4) begin
              hit_nxt   = 1'b1;
              hport_nxt = cport_nxt ^ stunmap_pkg::MAGIC_COOKIE[31:16];
              haddr_nxt = caddr_nxt ^ stunmap_pkg::MAGIC_COOKIE;
              stop_nxt  = 1'b1;
            end else begin
              pad = ~len_r[1:0] + 2'd1;
              if (pad == 2'd0) begin
                phase_nxt = stunmap_pkg::PH_HEAD;
              end else begin
                phase_nxt = stunmap_pkg::PH_PAD;
                left_nxt  = {14'd0, pad};
              end
            end
          end
        end
        stunmap_pkg::PH_PAD: begin
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            phase_nxt = stunmap_pkg::PH_HEAD;
          end
        end
        default: begin
          case (hcnt_r)
            2'd0:    kind_nxt = {data_byte, 8'h00};
            2'd1:    kind_nxt = kind_r | {8'h00, data_byte};
            2'd2:    len_nxt  = {data_byte, 8'h00};
            default: len_nxt  = len_r | {8'h00, data_byte};
          endcase
          if (hcnt_r == 2'd3) begin
            hcnt_nxt  = 2'd0;
            fam_nxt   = 8'h00;
            cport_nxt = 16'h0000;
            caddr_nxt = 32'h0000_0000;
            if (len_nxt == 16'd0) begin
              phase_nxt = stunmap_pkg::PH_HEAD;
            end else begin
              phase_nxt = stunmap_pkg::PH_VALUE;
              left_nxt  = len_nxt;
            end
          end else begin
            hcnt_nxt = hcnt_r + 2'd1;
          end
        end
      endcase
    end
  end

  assign result.found    = hit_nxt;
  assign result.ext_addr = hit_nxt ? haddr_nxt : 32'h0000_0000;
  assign result.ext_port = hit_nxt ? hport_nxt : 16'h0000;

  always_ff @(posedge clk) begin
    if (!rst_n || (beat_en && last)) begin
      pos_r   <= 16'd0;
      hg_r    <= 1'b0;
      phase_r <= stunmap_pkg::PH_HEAD;
      stop_r  <= 1'b0;
      hcnt_r  <= 2'd0;
      kind_r  <= 16'd0;
      len_r   <= 16'd0;
      left_r  <= 16'd0;
      fam_r   <= 8'd0;
      cport_r <= 16'd0;
      caddr_r <= 32'd0;
      hit_r   <= 1'b0;
      hport_r <= 16'd0;
      haddr_r <= 32'd0;
    end else if (beat_en) begin
      pos_r   <= pos_nxt;
      hg_r    <= hg_nxt;
      phase_r <= phase_nxt;
      stop_r  <= stop_nxt;
      hcnt_r  <= hcnt_nxt;
      kind_r  <= kind_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      fam_r   <= fam_nxt;
      cport_r <= cport_nxt;
      caddr_r <= caddr_nxt;
      hit_r   <= hit_nxt;
      hport_r <= hport_nxt;
      haddr_r <= haddr_nxt;
    end
  end

endmodule

/* sv/stun_mapped_address_parser.sv */
// ----------------------------------------------------------------------------
// STUN mapped-address parser
// Checks the binding response header, walks the attributes and returns the
// XOR-decoded IPv4 address and port once per datagram.
//
//   channel | dir | beat
//   in_ch   | in  | data_byte, end_of_datagram (one datagram byte)
//   out_ch  | out | found, ext_addr, ext_port (one per datagram)
//
// One byte is taken every cycle while in_ch.ready is high; the walker state
// updates at the accepting edge and the result is registered at the edge of
// the last byte. A result register plus a skid register keep input flowing
// while out_ch stalls; in_ch.ready drops only when both are full.
// Reset is synchronous, active low, and clears walker and output valids.
// ----------------------------------------------------------------------------
module stun_mapped_address_parser (
  input  logic          clk,
  input  logic          rst_n,
  stunmap_in_if.sink    in_ch,
  stunmap_out_if.source out_ch
);

  stunmap_pkg::result_t res;
  stunmap_pkg::result_t out_d_r, out_d_nxt;
  stunmap_pkg::result_t skid_d_r, skid_d_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 skid_v_r, skid_v_nxt;
  logic                 beat_en;
  logic                 push;
  logic                 pop;

  assign in_ch.ready = !skid_v_r;
  assign beat_en     = in_ch.valid && in_ch.ready;
  assign push        = beat_en && in_ch.end_of_datagram;
  assign pop         = out_v_r && out_ch.ready;

  stunmap_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_en   (beat_en),
    .data_byte (in_ch.data_byte),
    .last      (in_ch.end_of_datagram),
    .result    (res)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (pop) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r && pop) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      if (out_v_nxt) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = res;
      end else begin
        out_v_nxt = 1'b1;
        out_d_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.found    = out_d_r.found;
  assign out_ch.ext_addr = out_d_r.ext_addr;
  assign out_ch.ext_port = out_d_r.ext_port;

endmodule

/* sim/stunmap_addr_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN mapped-address checker
// Follows every accepted datagram byte with its own attribute walker and
// compares each result beat with the oldest predicted mapping.
// ----------------------------------------------------------------------------
module stunmap_addr_checker (
  input  logic   clk,
  input  logic   rst_n,
  stunmap_in_if  in_ch,
  stunmap_out_if out_ch,
  output int     mismatches,
  output int     awaiting
);
  import stunmap_pkg::*;

  logic [15:0] pos;
  logic        hdr_ok;
  walk_phase_t phase;
  logic        halted;
  logic [1:0]  tl_count;
  logic [15:0] a_kind;
  logic [15:0] a_len;
  logic [15:0] left;
  logic [7:0]  fam;
  logic [15:0] port_raw;
  logic [31:0] addr_raw;
  logic        hit;
  logic [15:0] hit_port;
  logic [31:0] hit_addr;
  result_t     expected_map[$];
  int          fails;

  function automatic void clear_walk();
    pos      = '0;
    hdr_ok   = 1'b0;
    phase    = PH_HEAD;
    halted   = 1'b0;
    tl_count = '0;
    a_kind   = '0;
    a_len    = '0;
    left     = '0;
    fam      = '0;
    port_raw = '0;
    addr_raw = '0;
    hit      = 1'b0;
    hit_port = '0;
    hit_addr = '0;
  endfunction

  function automatic void skip_padding();
    logic [1:0] pad;
    pad = 2'd0 - a_len[1:0];
    if (pad == 2'd0) begin
      phase = PH_HEAD;
    end else begin
      phase = PH_PAD;
      left  = {14'd0, pad};
    end
  endfunction

  function automatic void walk_attr_byte(input logic [7:0] b);
    logic [15:0] k;
    case (phase)
      PH_VALUE: begin
        k = a_len - left;
        if (k == 16'd1) begin
          fam = b;
        end else if (k == 16'd2) begin
          port_raw = {b, 8'h00};
        end else if (k == 16'd3) begin
          port_raw = port_raw | {8'h00, b};
        end else if (k >= 16'd4 && k <= 16'd7) begin
          addr_raw = {addr_raw[23:0], b};
        end
        left = left - 16'd1;
        if (left == 16'd0) begin
          if (hdr_ok && a_kind == ATTR_XOR_MAPPED && a_len >= MIN_ATTR_LEN &&
              fam == FAMILY_IPV4) begin
            hit      = 1'b1;
            hit_port = port_raw ^ MAGIC_COOKIE[31:16];
            hit_addr = addr_raw ^ MAGIC_COOKIE;
            halted   = 1'b1;
          end else begin
            skip_padding();
          end
        end
      end
      PH_PAD: begin
        left = left - 16'd1;
        if (left == 16'd0) phase = PH_HEAD;
      end
      default: begin
        case (tl_count)
          2'd0: a_kind = {b, 8'h00};
          2'd1: a_kind = a_kind | {8'h00, b};
          2'd2: a_len  = {b, 8'h00};
          default: a_len = a_len | {8'h00, b};
        endcase
        if (tl_count == 2'd3) begin
          tl_count = '0;
          fam      = '0;
          port_raw = '0;
          addr_raw = '0;
          if (a_len == 16'd0) begin
            skip_padding();
          end else begin
            phase = PH_VALUE;
            left  = a_len;
          end
        end else begin
          tl_count = tl_count + 2'd1;
        end
      end
    endcase
  endfunction

  function automatic void track_datagram_byte(input logic [7:0] b, input logic last);
    result_t r;
    if (pos == 16'd0) begin
      hdr_ok = (b == HEADER_BYTE);
    end else if (pos == 16'd1) begin
      hdr_ok = hdr_ok && (b == HEADER_BYTE);
    end else if (pos >= HEADER_LEN && !halted) begin
      walk_attr_byte(b);
    end
    if (pos != POS_MAX) pos = pos + 16'd1;
    if (last) begin
      r.found    = hit;
      r.ext_addr = hit ? hit_addr : 32'd0;
      r.ext_port = hit ? hit_port : 16'd0;
      expected_map.push_back(r);
      clear_walk();
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_walk();
      expected_map.delete();
      fails = 0;
      mismatches <= 0;
      awaiting <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_map.size() == 0) begin
          if (fails < 10)
            $display("%0t: result beat with nothing predicted: found %0b addr %08h port %04h",
                     $realtime, out_ch.found, out_ch.ext_addr, out_ch.ext_port);
          fails++;
        end else begin
          want = expected_map.pop_front();
          if (out_ch.found !== want.found || out_ch.ext_addr !== want.ext_addr ||
              out_ch.ext_port !== want.ext_port) begin
            if (fails < 10)
              $display("%0t: got found %0b addr %08h port %04h, want found %0b addr %08h port %04h",
                       $realtime, out_ch.found, out_ch.ext_addr, out_ch.ext_port,
                       want.found, want.ext_addr, want.ext_port);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        track_datagram_byte(in_ch.data_byte, in_ch.end_of_datagram);
      mismatches <= fails;
      awaiting <= expected_map.size();
    end
  end

endmodule

/* sim/tb_stun_mapped_address_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STUN mapped-address parser testbench
// Feeds directed and random datagrams byte by byte under varying sender and
// receiver idling, including a long receiver hold, and leaves prediction and
// comparison to the checker beside the parser.
// ----------------------------------------------------------------------------
module tb_stun_mapped_address_parser;
  import stunmap_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 100;
  localparam int PHASE_DGRAMS   = 3;

  logic       clk;
  logic       rst_n;
  int         mismatches;
  int         awaiting;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_requests;
  int         hold_served;
  int         stalled_cycles;
  int         sent_bytes;
  int         sent_dgrams;
  logic [7:0] dgram[$];

  stunmap_in_if  in_ch ();
  stunmap_out_if out_ch ();

  stun_mapped_address_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stunmap_addr_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_datagram <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_beat(dgram[i], i == dgram.size() - 1);
    sent_bytes += dgram.size();
    sent_dgrams++;
    dgram.delete();
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
  endtask

  task automatic put_fill(input int n);
    repeat (n) dgram.push_back(8'($urandom));
  endtask

  task automatic put_header(input logic [7:0] b0, input logic [7:0] b1);
    dgram.push_back(b0);
    dgram.push_back(b1);
    put_fill(18);
  endtask

  task automatic put_tl(input logic [15:0] kind, input logic [15:0] len);
    dgram.push_back(kind[15:8]);
    dgram.push_back(kind[7:0]);
    dgram.push_back(len[15:8]);
    dgram.push_back(len[7:0]);
  endtask

  task automatic put_attr(input logic [15:0] kind, input logic [15:0] len,
                          input logic [7:0] family, input logic [15:0] port,
                          input logic [31:0] addr);
    logic [7:0] val [8];
    val = '{8'($urandom), family, port[15:8], port[7:0],
            addr[31:24], addr[23:16], addr[15:8], addr[7:0]};
    put_tl(kind, len);
    for (int i = 0; i < int'(len); i++) dgram.push_back(i < 8 ? val[i] : 8'($urandom));
    put_fill((4 - int'(len[1:0])) % 4);
  endtask

  task automatic build_random_dgram();
    int          kind;
    int          n;
    logic [15:0] ak;
    logic [15:0] alen;
    logic [7:0]  afam;
    kind = $urandom_range(99);
    if (kind < 70) begin
      put_header(HEADER_BYTE, HEADER_BYTE);
      repeat ($urandom_range(3)) begin
        ak   = ($urandom_range(1) == 1) ? ATTR_XOR_MAPPED : 16'($urandom);
        alen = ($urandom_range(7) == 0) ? 16'($urandom_range(40, 13)) : 16'($urandom_range(12));
        afam = ($urandom_range(3) == 0) ? 8'($urandom) : FAMILY_IPV4;
        put_attr(ak, alen, afam, 16'($urandom), $urandom);
      end
      if ($urandom_range(3) == 0) put_fill($urandom_range(6, 1));
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(dgram.size() - 1, 1)) void'(dgram.pop_back());
      end
    end else if (kind < 85) begin
      put_fill($urandom_range(40, 1));
      if ($urandom_range(3) == 0 && dgram.size() >= 2) begin
        dgram[0] = HEADER_BYTE;
        dgram[1] = HEADER_BYTE;
      end
    end else if ($urandom_range(1) == 1) begin
      put_header(HEADER_BYTE, HEADER_BYTE);
      n = $urandom_range(19, 2);
      while (dgram.size() > n) void'(dgram.pop_back());
    end else begin
      if ($urandom_range(1) == 1) begin
        put_header(8'($urandom), HEADER_BYTE);
      end else begin
        put_header(HEADER_BYTE, 8'($urandom));
      end
      put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'($urandom), $urandom);
    end
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct);
    int start_bytes;
    int start_dgrams;
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    start_bytes  = sent_bytes;
    start_dgrams = sent_dgrams;
    while (sent_bytes - start_bytes < PHASE_BYTES || sent_dgrams - start_dgrams < PHASE_DGRAMS)
    begin
      build_random_dgram();
      send_dgram();
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.end_of_datagram <= 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 60;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // clean hits with all-ones and all-zero fields
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'hFFFF, 32'hFFFF_FFFF);
    send_dgram();
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h0000, 32'h0000_0000);
    send_dgram();
    // short datagrams
    dgram.push_back(8'hFF);
    send_dgram();
    dgram.push_back(8'h00);
    send_dgram();
    put_header(HEADER_BYTE, HEADER_BYTE);
    void'(dgram.pop_back());
    send_dgram();
    // bad header with a matching attribute
    put_header(8'h00, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h1234, 32'hC0A8_0101);
    send_dgram();
    put_header(HEADER_BYTE, 8'hFF);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h1234, 32'hC0A8_0101);
    send_dgram();
    // cut inside the type-length word, then inside the value
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h5555, 32'hAAAA_5555);
    repeat (10) void'(dgram.pop_back());
    send_dgram();
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h5555, 32'hAAAA_5555);
    repeat (3) void'(dgram.pop_back());
    send_dgram();
    // end right after the value of a matching attribute, before its padding
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, 16'd10, FAMILY_IPV4, 16'hBEEF, 32'h0A00_0001);
    repeat (2) void'(dgram.pop_back());
    send_dgram();
    // wrong family, then a good one
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, 8'h02, 16'h1111, 32'h1111_1111);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h2222, 32'h2222_2222);
    send_dgram();
    // too short a value, then a long one
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, 16'd4, FAMILY_IPV4, 16'h3333, 32'h3333_3333);
    put_attr(ATTR_XOR_MAPPED, 16'd12, FAMILY_IPV4, 16'h4444, 32'h4444_4444);
    send_dgram();
    // zero length, other type, a hit, a second hit and trailing bytes
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_attr(ATTR_XOR_MAPPED, 16'd0, FAMILY_IPV4, 16'h0, 32'h0);
    put_attr(16'hFFFF, 16'd5, FAMILY_IPV4, 16'h6666, 32'h6666_6666);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h7777, 32'h7777_7777);
    put_attr(ATTR_XOR_MAPPED, MIN_ATTR_LEN, FAMILY_IPV4, 16'h8888, 32'h8888_8888);
    put_fill(7);
    send_dgram();
    // huge length cut off by the end
    put_header(HEADER_BYTE, HEADER_BYTE);
    put_tl(ATTR_XOR_MAPPED, 16'hFFFF);
    put_fill(10);
    send_dgram();
    wait_results_drained();

    run_random_phase(9, 60);

    // hold the receiver while short datagrams keep coming
    hold_requests <= hold_requests + 1;
    repeat (30) begin
      put_fill($urandom_range(6, 1));
      send_dgram();
    end
    wait_results_drained();

    run_random_phase(60, 9);
    run_random_phase(0, 0);

    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
sv/stunmap_pkg.sv
sv/stunmap_in_if.sv
sv/stunmap_out_if.sv
sv/stunmap_walk.sv
sv/stun_mapped_address_parser.sv
sim/stunmap_addr_checker.sv
sim/tb_stun_mapped_address_parser.sv
